### design/lcg48_bounded_random_generator_core_assert.svh
// assertion macros for the lcg48 generator core
`ifndef LCG48_BOUNDED_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define LCG48_BOUNDED_RANDOM_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked outside reset
`define LCG48_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcg48 assertion failed");

// checked on every edge, reset included
`define LCG48_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lcg48 assertion failed");

`else

`define LCG48_ASSERT(label, clk, rst, prop)
`define LCG48_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### design/lcg48_pkg.sv
`default_nettype none

package lcg48_pkg;

  localparam int STATE_BITS  = 48;
  localparam int DRAW_BITS   = 31;
  localparam int HI_BITS     = 26;
  localparam int LO_BITS     = 27;
  localparam int VALUE_BITS  = 53;
  localparam int OP_W        = 2;
  localparam int BC_W        = 5;
  localparam int BOUND_W     = 31;
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = 3;
  localparam int DIGIT_SEL_W = 2;
  localparam int MAX_DRAWS   = 256;
  localparam int CNT_W       = $clog2(DRAW_BITS);
  localparam int TRY_W       = $clog2(MAX_DRAWS);
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 5;
  localparam int SHIFT_W     = 6;

  localparam logic [STATE_BITS-1:0] SEED_RESET = 48'd0;
  localparam logic [STATE_BITS-1:0] MULT_RESET = 48'h5_DEEC_E66D;
  localparam logic [STATE_BITS-1:0] INCR_RESET = 48'hB;

  localparam logic [1:0] REG_SEED       = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_INCREMENT  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_RAW      = 2'd0,
    OP_BOUNDED  = 2'd1,
    OP_FRACTION = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_RAW,
    RES_POW2,
    RES_REM,
    RES_FRAC
  } res_sel_t;

  typedef struct packed {
    logic                  seed_load;
    logic [STATE_BITS-1:0] seed;
    logic [STATE_BITS-1:0] multiplier;
    logic [STATE_BITS-1:0] increment;
  } cfg_t;

  typedef struct packed {
    logic                   load_in;
    logic                   mul_step;
    logic                   mul_first;
    logic                   mul_last;
    logic [DIGIT_SEL_W-1:0] digit;
    logic                   div_init;
    logic                   div_step;
    logic                   hi_load;
    logic                   res_load;
    res_sel_t               res_sel;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic is_pow2;
    logic reject;
  } dp_status_t;

endpackage

`default_nettype wire

### design/lcg48_regs.sv
`default_nettype none

module lcg48_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lcg48_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lcg48_pkg::DATA_W-1:0] pwdata,
  output logic      [lcg48_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  output lcg48_pkg::cfg_t                   cfg
);
  import lcg48_pkg::*;

  logic [STATE_BITS-1:0] seed_value;
  logic [STATE_BITS-1:0] multiplier;
  logic [STATE_BITS-1:0] increment;
  logic                  wr;
  logic [1:0]            idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= SEED_RESET;
      multiplier <= MULT_RESET;
      increment  <= INCR_RESET;
    end else if (wr) begin
      case (idx)
        REG_SEED:       seed_value <= pwdata[STATE_BITS-1:0];
        REG_MULTIPLIER: multiplier <= pwdata[STATE_BITS-1:0];
        REG_INCREMENT:  increment  <= pwdata[STATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEED:       prdata = DATA_W'(seed_value);
      REG_MULTIPLIER: prdata = DATA_W'(multiplier);
      REG_INCREMENT:  prdata = DATA_W'(increment);
      default:        prdata = '0;
    endcase
  end

  // seed write reloads the generator state directly
  assign cfg.seed_load  = wr && (idx == REG_SEED);
  assign cfg.seed       = pwdata[STATE_BITS-1:0];
  assign cfg.multiplier = multiplier;
  assign cfg.increment  = increment;

endmodule

`default_nettype wire

### design/lcg48_dp.sv
`default_nettype none

module lcg48_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lcg48_pkg::cfg_t               cfg,
  input  wire lcg48_pkg::dp_cmd_t            cmd,
  input  wire logic [lcg48_pkg::OP_W-1:0]    op,
  input  wire logic [lcg48_pkg::BC_W-1:0]    bit_count,
  input  wire logic [lcg48_pkg::BOUND_W-1:0] bound,
  output lcg48_pkg::dp_status_t              status,
  output logic [lcg48_pkg::VALUE_BITS-1:0]   value
);
  import lcg48_pkg::*;

  logic [STATE_BITS-1:0] lcg_state;
  logic [STATE_BITS-1:0] acc;
  logic [OP_W-1:0]       op_q;
  logic [BC_W-1:0]       bc_q;
  logic [BOUND_W-1:0]    bound_q;
  logic [HI_BITS-1:0]    hi;
  logic [DRAW_BITS-1:0]  draw_b;
  logic [DRAW_BITS-1:0]  div_bits;
  logic [BOUND_W-1:0]    rem;
  logic [VALUE_BITS-1:0] value_q;

  logic [DIGIT_W-1:0]    digit;
  logic [63:0]           prod;
  logic [STATE_BITS-1:0] partial;
  logic [STATE_BITS-1:0] acc_sum;
  logic [BOUND_W:0]      trial;
  logic [BOUND_W:0]      trial_sub;
  logic [31:0]           t;
  logic [DRAW_BITS-1:0]  draw_now;
  logic [SHIFT_W-1:0]    raw_sh;
  logic [STATE_BITS-1:0] raw48;
  logic [DRAW_BITS-1:0]  pow2_val;
  logic [VALUE_BITS-1:0] res;

  // one 16-bit digit of the state per step, shifted into place mod 2^48
  always_comb begin
    unique case (cmd.digit)
      2'd0:    digit = lcg_state[15:0];
      2'd1:    digit = lcg_state[31:16];
      2'd2:    digit = lcg_state[47:32];
      default: digit = '0;
    endcase
    prod = 64'(digit) * 64'(cfg.multiplier);
    unique case (cmd.digit)
      2'd0:    partial = prod[47:0];
      2'd1:    partial = {prod[31:0], 16'b0};
      2'd2:    partial = {prod[15:0], 32'b0};
      default: partial = '0;
    endcase
    acc_sum = (cmd.mul_first ? cfg.increment : acc) + partial;
  end

  assign draw_now  = lcg_state[STATE_BITS-1 -: DRAW_BITS];
  assign trial     = {rem, div_bits[DRAW_BITS-1]};
  assign trial_sub = trial - {1'b0, bound_q};

  // java rejection test: b - v + (n - 1) as a wrapping signed 32-bit sum
  assign t = 32'(draw_b) - 32'(rem) + 32'(bound_q) - 32'd1;

  assign raw_sh = SHIFT_W'(STATE_BITS) - SHIFT_W'(bc_q);
  assign raw48  = lcg_state >> raw_sh;

  always_comb begin
    pow2_val = '0;
    for (int i = 0; i < BOUND_W; i++) begin
      if (bound_q[i]) pow2_val = draw_now >> (DRAW_BITS - i);
    end
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_ZERO: res = '0;
      RES_RAW:  res = VALUE_BITS'(raw48);
      RES_POW2: res = VALUE_BITS'(pow2_val);
      RES_REM:  res = VALUE_BITS'(rem);
      RES_FRAC: res = {hi, lcg_state[STATE_BITS-1 -: LO_BITS]};
      default:  res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= SEED_RESET;
    end else if (cfg.seed_load) begin
      lcg_state <= cfg.seed;
    end else if (cmd.mul_step && cmd.mul_last) begin
      lcg_state <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= op;
      bc_q    <= bit_count;
      bound_q <= bound;
    end
    if (cmd.mul_step) acc <= acc_sum;
    if (cmd.hi_load) hi <= lcg_state[STATE_BITS-1 -: HI_BITS];
    if (cmd.div_init) begin
      draw_b   <= draw_now;
      div_bits <= draw_now;
      rem      <= '0;
    end else if (cmd.div_step) begin
      div_bits <= div_bits << 1;
      if (!trial_sub[BOUND_W]) rem <= trial_sub[BOUND_W-1:0];
      else                     rem <= trial[BOUND_W-1:0];
    end
    if (cmd.res_load) value_q <= res;
  end

  assign status.op      = op_t'(op_q);
  assign status.is_pow2 = (bound_q & (~bound_q + BOUND_W'(1))) == bound_q;
  assign status.reject  = t[31];
  assign value          = value_q;

endmodule

`default_nettype wire

### design/lcg48_ctrl.sv
`default_nettype none

`include "lcg48_bounded_random_generator_core_assert.svh"

module lcg48_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic [lcg48_pkg::OP_W-1:0] op,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  input  wire lcg48_pkg::dp_status_t      status,
  output lcg48_pkg::dp_cmd_t              cmd
);
  import lcg48_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_POST,
    S_DIV,
    S_CHK,
    S_FIN
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [TRY_W-1:0]   tries;
  logic               phase;
  res_sel_t           res_sel;
  logic               slot_free;
  logic               last_try;

  assign item_stall = (state != S_IDLE);
  assign slot_free  = !result_valid || !result_stall;
  assign last_try   = (tries == TRY_W'(MAX_DRAWS - 1));

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = res_sel;
    cmd.load_in   = (state == S_IDLE) && item_valid;
    cmd.mul_step  = (state == S_ADV);
    cmd.digit     = cnt[DIGIT_SEL_W-1:0];
    cmd.mul_first = (cnt == '0);
    cmd.mul_last  = (cnt == CNT_W'(NUM_DIGITS - 1));
    cmd.div_init  = (state == S_POST) && (status.op == OP_BOUNDED) && !status.is_pow2;
    cmd.div_step  = (state == S_DIV);
    cmd.hi_load   = (state == S_POST) && (status.op == OP_FRACTION) && !phase;
    cmd.res_load  = (state == S_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      tries        <= '0;
      phase        <= 1'b0;
      res_sel      <= RES_ZERO;
      result_valid <= 1'b0;
    end else begin
      // raise the result as the request finishes, else drop it once taken
      if ((state == S_FIN) && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cnt   <= '0;
            tries <= '0;
            phase <= 1'b0;
            if (op_t'(op) == OP_UNUSED) begin
              res_sel <= RES_ZERO;
              state   <= S_FIN;
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (cnt == CNT_W'(NUM_DIGITS - 1)) begin
            cnt   <= '0;
            state <= S_POST;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_POST: begin
          unique case (status.op)
            OP_RAW: begin
              res_sel <= RES_RAW;
              state   <= S_FIN;
            end
            OP_BOUNDED: begin
              if (status.is_pow2) begin
                res_sel <= RES_POW2;
                state   <= S_FIN;
              end else begin
                state <= S_DIV;
              end
            end
            OP_FRACTION: begin
              // high 26 bits first, then a second advance for the low 27
              if (!phase) begin
                phase <= 1'b1;
                state <= S_ADV;
              end else begin
                res_sel <= RES_FRAC;
                state   <= S_FIN;
              end
            end
            OP_UNUSED: begin
              res_sel <= RES_ZERO;
              state   <= S_FIN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (cnt == CNT_W'(DRAW_BITS - 1)) begin
            cnt   <= '0;
            state <= S_CHK;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_CHK: begin
          // give up after the last allowed draw and keep its remainder
          if (status.reject && !last_try) begin
            tries <= tries + TRY_W'(1);
            state <= S_ADV;
          end else begin
            res_sel <= RES_REM;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LCG48_ASSERT(a_chk_after_div, clk, rst, (state == S_CHK) |-> ($past(state) == S_DIV))
  `LCG48_ASSERT(a_accept_leaves_idle, clk, rst, cmd.load_in |=> (state != S_IDLE))
  `LCG48_ASSERT(a_retry_limit, clk, rst, ((state == S_CHK) && last_try) |=> (state == S_FIN))
  `LCG48_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!result_valid && (state == S_IDLE)))

endmodule

`default_nettype wire

### design/lcg48_bounded_random_generator_core.sv
// from request accept to result valid: the unused op goes straight to its result; raw bits
// and power-of-two bounds take one state advance, a 53-bit fraction two, other bounds an
// advance and a remainder per draw (1 to 256 draws); advances run digit by digit in the 16x48
// multiply-accumulate unit, remainders bit by bit in the bit-serial divider; one request is in
// flight, the next is taken as the result is raised, a stalled result holds the next in S_FIN
// synchronous active-high reset: state 0, multiplier 0x5DEECE66D, increment 0xB, no result.
`default_nettype none

module lcg48_bounded_random_generator_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic [lcg48_pkg::OP_W-1:0]        op,
  input  wire logic [lcg48_pkg::BC_W-1:0]        bit_count,
  input  wire logic [lcg48_pkg::BOUND_W-1:0]     bound,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic      [lcg48_pkg::VALUE_BITS-1:0]  value,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lcg48_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [lcg48_pkg::DATA_W-1:0]      pwdata,
  output logic      [lcg48_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready
);
  import lcg48_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lcg48_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcg48_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lcg48_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .op        (op),
    .bit_count (bit_count),
    .bound     (bound),
    .status    (status),
    .value     (value)
  );

endmodule

`default_nettype wire
